/* rtl/mass_window_range_search_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mass window range search block.
// ----------------------------------------------------------------------------
`ifndef MASS_WINDOW_RANGE_SEARCH_MACROS_SVH
`define MASS_WINDOW_RANGE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWRS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("mwrs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MWRS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("mwrs: next-cycle check failed");

`endif

/* rtl/mwrs_pkg.sv */
// ----------------------------------------------------------------------------
// mwrs_pkg
// Shared widths, codes and types of the mass window range search block.
// ----------------------------------------------------------------------------
package mwrs_pkg;

  localparam int MASS_W    = 32;
  localparam int IDX_W     = 16;
  localparam int COUNT_W   = 17;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 32;
  localparam int WIN_W     = 34;

  // Item opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 8'd1;

  localparam logic [MASS_W-1:0]  TOL_RESET   = 32'd655360;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_RD_FIRST,
    ST_CHECK,
    ST_INIT,
    ST_SEARCH,
    ST_RD_LOW,
    ST_RD_HIGH,
    ST_FLAG,
    ST_OUT
  } state_t;

endpackage

/* rtl/mwrs_in_if.sv */
// ----------------------------------------------------------------------------
// mwrs_in_if
// Input item channel: load or query transactions.
// ----------------------------------------------------------------------------
interface mwrs_in_if
  import mwrs_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [IDX_W-1:0]  entry_index;
  logic [MASS_W-1:0] entry_mass;
  logic [MASS_W-1:0] query_mass;

  modport source (output valid, op, entry_index, entry_mass, query_mass, input ready);
  modport sink   (input valid, op, entry_index, entry_mass, query_mass, output ready);
endinterface

/* rtl/mwrs_out_if.sv */
// ----------------------------------------------------------------------------
// mwrs_out_if
// Result channel: index range of one query.
// ----------------------------------------------------------------------------
interface mwrs_out_if
  import mwrs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] low_index;
  logic [IDX_W-1:0] high_index;
  logic             in_window;

  modport source (output valid, low_index, high_index, in_window, input ready);
  modport sink   (input valid, low_index, high_index, in_window, output ready);
endinterface

/* rtl/mwrs_cfg_if.sv */
// ----------------------------------------------------------------------------
// mwrs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mwrs_cfg_if
  import mwrs_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mwrs_ram.sv */
// ----------------------------------------------------------------------------
// mwrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/mass_window_range_search.sv */
// ----------------------------------------------------------------------------
// mass_window_range_search
// A load is written as it is taken; the block stays idle and ready for the next item.
// A query holds the block busy until its result is taken; one transaction is
// in work at a time.
// The single RAM read port sets the pace of a query: one bisection step per cycle.
// Reset loads the register defaults; the mass table is not cleared.
// ----------------------------------------------------------------------------
module mass_window_range_search
  import mwrs_pkg::*;
#(
  parameter int TABLE_DEPTH = 65536
) (
  input logic       clk,
  input logic       rst_n,
  mwrs_in_if.sink   in_ch,
  mwrs_out_if.source out_ch,
  mwrs_cfg_if.sink  cfg_ch
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int WIDE_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int CAP    = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
  localparam logic [COUNT_W-1:0] CAP_L   = COUNT_W'(CAP);
  localparam logic [24:0]        DEPTH_L = 25'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic signed [MASS_W-1:0] tol_r;
  logic [COUNT_W-1:0]       cnt_r;
  logic signed [WIN_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic [IDX_W-1:0]         last_r, last_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IDX_W-1:0]         low_r, low_nxt, high_r, high_nxt;
  logic                     upper_r, upper_nxt;
  logic                     above_r, above_nxt, lclamp_r, lclamp_nxt;
  logic                     hclamp_r, hclamp_nxt, lowok_r, lowok_nxt;
  logic                     flag_r, flag_nxt;

  logic                     in_acc, wr_en, rd_en;
  logic [IDX_W-1:0]         rd_idx;
  logic [MASS_W-1:0]        rd_data;
  logic signed [WIN_W-1:0]  mass_s, q_s, tol_s;
  logic                     lt_p1, gt_p1, lt_p2, gt_p2;
  logic [COUNT_W-1:0]       n_act, n_m1;
  logic [IDX_W-1:0]         lo_n, hi_n;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(i);
    return w[ADDR_W-1:0];
  endfunction

  // Floor midpoint for the lower bound, ceiling midpoint for the upper bound.
  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                               input logic [IDX_W-1:0] hi,
                                               input logic             up);
    logic [IDX_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} + {{IDX_W{1'b0}}, up};
    return sum[IDX_W:1];
  endfunction

  mwrs_ram #(
    .WIDTH (MASS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (to_addr(in_ch.entry_index)),
    .wr_data (in_ch.entry_mass),
    .rd_en   (rd_en),
    .rd_addr (to_addr(rd_idx)),
    .rd_data (rd_data)
  );

  assign in_acc = in_ch.valid && in_ch.ready;
  assign wr_en  = in_acc && (in_ch.op == OP_LOAD) && (25'(in_ch.entry_index) < DEPTH_L);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      cnt_r <= COUNT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TOLERANCE) begin
        tol_r <= cfg_ch.data;
      end else if (cfg_ch.index == REG_ENTRY_COUNT) begin
        cnt_r <= cfg_ch.data[COUNT_W-1:0];
      end
    end
  end

  // Active entry count: zero reads as one, large values saturate.
  always_comb begin
    if (cnt_r == '0) begin
      n_act = COUNT_W'(1);
    end else if (cnt_r > CAP_L) begin
      n_act = CAP_L;
    end else begin
      n_act = cnt_r;
    end
    n_m1 = n_act - COUNT_W'(1);
  end

  // Shared compare unit: the mass just read against both window ends.
  assign mass_s = $signed({2'b00, rd_data});
  assign q_s    = $signed({2'b00, in_ch.query_mass});
  assign tol_s  = {{(WIN_W - MASS_W){tol_r[MASS_W-1]}}, tol_r};
  assign lt_p1  = mass_s < p1_r;
  assign gt_p1  = mass_s > p1_r;
  assign lt_p2  = mass_s < p2_r;
  assign gt_p2  = mass_s > p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    last_r   <= last_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    low_r    <= low_nxt;
    high_r   <= high_nxt;
    upper_r  <= upper_nxt;
    above_r  <= above_nxt;
    lclamp_r <= lclamp_nxt;
    hclamp_r <= hclamp_nxt;
    lowok_r  <= lowok_nxt;
    flag_r   <= flag_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    last_nxt   = last_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    upper_nxt  = upper_r;
    above_nxt  = above_r;
    lclamp_nxt = lclamp_r;
    hclamp_nxt = hclamp_r;
    lowok_nxt  = lowok_r;
    flag_nxt   = flag_r;
    rd_en      = 1'b0;
    rd_idx     = '0;
    lo_n       = lo_r;
    hi_n       = hi_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.op == OP_QUERY) begin
          p1_nxt   = q_s - tol_s;
          p2_nxt   = q_s + tol_s;
          last_nxt = n_m1[IDX_W-1:0];
          if (tol_r[MASS_W-1]) begin
            low_nxt   = '0;
            high_nxt  = n_m1[IDX_W-1:0];
            flag_nxt  = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RD_LAST;
          end
        end
      end
      ST_RD_LAST: begin
        rd_en     = 1'b1;
        rd_idx    = last_r;
        state_nxt = ST_RD_FIRST;
      end
      ST_RD_FIRST: begin
        // Read data is the last entry here.
        above_nxt  = lt_p1;
        hclamp_nxt = lt_p2;
        rd_en      = 1'b1;
        rd_idx     = '0;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        // Read data is the first entry here.
        flag_nxt = 1'b0;
        if (above_r) begin
          low_nxt   = last_r;
          high_nxt  = last_r;
          state_nxt = ST_OUT;
        end else if (gt_p2) begin
          low_nxt   = '0;
          high_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          lclamp_nxt = gt_p1;
          lo_nxt     = '0;
          hi_nxt     = last_r;
          upper_nxt  = 1'b0;
          state_nxt  = ST_INIT;
        end
      end
      ST_INIT: begin
        if ((!upper_r && lclamp_r) || (upper_r && hclamp_r) || lo_r == hi_r) begin
          if (!upper_r) begin
            low_nxt   = lclamp_r ? '0 : lo_r;
            upper_nxt = 1'b1;
            lo_nxt    = '0;
            hi_nxt    = last_r;
            state_nxt = ST_INIT;
          end else begin
            high_nxt  = hclamp_r ? last_r : lo_r;
            state_nxt = ST_RD_LOW;
          end
        end else begin
          mid_nxt   = mid_of(lo_r, hi_r, upper_r);
          rd_en     = 1'b1;
          rd_idx    = mid_nxt;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The read of mid_r completes now; the next midpoint is issued at once.
        if (!upper_r) begin
          if (lt_p1) begin
            lo_n = mid_r + IDX_W'(1);
          end else begin
            hi_n = mid_r;
          end
        end else begin
          if (gt_p2) begin
            hi_n = mid_r - IDX_W'(1);
          end else begin
            lo_n = mid_r;
          end
        end
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (lo_n < hi_n) begin
          mid_nxt = mid_of(lo_n, hi_n, upper_r);
          rd_en   = 1'b1;
          rd_idx  = mid_nxt;
        end else if (!upper_r) begin
          low_nxt   = lo_n;
          upper_nxt = 1'b1;
          lo_nxt    = '0;
          hi_nxt    = last_r;
          state_nxt = ST_INIT;
        end else begin
          high_nxt  = lo_n;
          state_nxt = ST_RD_LOW;
        end
      end
      ST_RD_LOW: begin
        rd_en     = 1'b1;
        rd_idx    = low_r;
        state_nxt = ST_RD_HIGH;
      end
      ST_RD_HIGH: begin
        lowok_nxt = !lt_p1;
        rd_en     = 1'b1;
        rd_idx    = high_r;
        state_nxt = ST_FLAG;
      end
      ST_FLAG: begin
        flag_nxt  = lowok_r && !gt_p2;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.low_index  = low_r;
  assign out_ch.high_index = high_r;
  assign out_ch.in_window  = flag_r;

endmodule

/* rtl/mwrs_checker.sv */
// ----------------------------------------------------------------------------
// mwrs_checker
// Port-level checks of the mass window range search block, bound to the top.
// ----------------------------------------------------------------------------
`include "mass_window_range_search_macros.svh"

module mwrs_checker
  import mwrs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_op,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_low,
  input logic [IDX_W-1:0] out_high,
  input logic             out_flag
);

  // A stalled result stays put.
  `MWRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_low) && $stable(out_high) && $stable(out_flag))

  // No new transaction is taken while a result waits.
  `MWRS_ASSERT_IMP(a_busy_on_result, clk, rst_n, out_valid, !in_ready)

  // A query keeps the input side closed in the following cycle.
  `MWRS_ASSERT_NXT(a_query_busy, clk, rst_n, in_valid && in_ready && in_op == OP_QUERY, !in_ready)

  // Once a result is taken the block is free again.
  `MWRS_ASSERT_NXT(a_free_after, clk, rst_n, out_valid && out_ready, in_ready && !out_valid)

endmodule

bind mass_window_range_search mwrs_checker u_mwrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_low   (out_ch.low_index),
  .out_high  (out_ch.high_index),
  .out_flag  (out_ch.in_window)
);

/* bench/mass_window_range_search_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mass_window_range_search_test
// Loads sorted, flat and unsorted mass tables, runs range queries under many
// tolerance and entry-count settings, and checks every returned index range
// against a behavioral predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module mass_window_range_search_test;
  import mwrs_pkg::*;

  localparam int TABLE_DEPTH   = 65536;
  localparam int RUN_LIMIT     = 2000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;
  localparam int TOTAL_ITEMS   = 1900;
  localparam int PREFIX_FILL   = 512;
  localparam logic [MASS_W-1:0] MASS_MAX = '1;

  typedef struct packed {
    logic [IDX_W-1:0] low_index;
    logic [IDX_W-1:0] high_index;
    logic             in_window;
  } window_t;

  typedef enum int {SHAPE_SORTED, SHAPE_TOP, SHAPE_UNSORTED, SHAPE_FLAT} shape_t;

  class window_scoreboard;
    bit [MASS_W-1:0]          masses [TABLE_DEPTH];
    logic signed [MASS_W-1:0] tolerance;
    logic [COUNT_W-1:0]       entry_count;
    window_t                  awaited[$];
    int                       errors;

    function new();
      tolerance   = TOL_RESET;
      entry_count = COUNT_RESET;
      errors      = 0;
    endfunction

    task report(string msg);
      if (errors < 100) begin
        $display("%0t mismatch: %s", $time, msg);
      end
      errors++;
    endtask

    function int entries_for(logic [COUNT_W-1:0] c);
      int cap;
      cap = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
      if (c == 0) return 1;
      if (c > cap) return cap;
      return c;
    endfunction

    function longint mass_of(int i);
      return longint'(masses[i]);
    endfunction

    function int first_at_or_above(longint p, int n);
      int lo, hi, mid;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (mass_of(mid) < p) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function int last_at_or_below(longint p, int n);
      int lo, hi, mid;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mass_of(mid) > p) hi = mid - 1;
        else lo = mid;
      end
      return lo;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_TOLERANCE:   tolerance = value;
        REG_ENTRY_COUNT: entry_count = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Loads update the table; each query predicts one index range.
    function void note_item(logic op, logic [IDX_W-1:0] idx, logic [MASS_W-1:0] emass,
                            logic [MASS_W-1:0] qmass);
      int      n, lo_i, hi_i;
      longint  tol, q, p1, p2;
      window_t w;
      if (op == OP_LOAD) begin
        if (idx < TABLE_DEPTH) masses[idx] = emass;
        return;
      end
      n   = entries_for(entry_count);
      tol = longint'(tolerance);
      q   = longint'(qmass);
      p1  = q - tol;
      p2  = q + tol;
      w.in_window = 1'b0;
      if (tol < 0) begin
        lo_i = 0;
        hi_i = n - 1;
      end else if (p1 > mass_of(n - 1)) begin
        lo_i = n - 1;
        hi_i = n - 1;
      end else if (p2 < mass_of(0)) begin
        lo_i = 0;
        hi_i = 0;
      end else begin
        lo_i = (p1 < mass_of(0)) ? 0 : first_at_or_above(p1, n);
        hi_i = (p2 > mass_of(n - 1)) ? n - 1 : last_at_or_below(p2, n);
        w.in_window = (mass_of(hi_i) <= p2) && (mass_of(lo_i) >= p1);
      end
      w.low_index  = lo_i[IDX_W-1:0];
      w.high_index = hi_i[IDX_W-1:0];
      awaited = {awaited, w};
    endfunction

    task check_result(window_t got);
      window_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: low %0d high %0d flag %0b",
                         got.low_index, got.high_index, got.in_window));
        return;
      end
      want = awaited.pop_front();
      if (got.low_index !== want.low_index)
        report($sformatf("low_index %0d, expected %0d", got.low_index, want.low_index));
      if (got.high_index !== want.high_index)
        report($sformatf("high_index %0d, expected %0d", got.high_index, want.high_index));
      if (got.in_window !== want.in_window)
        report($sformatf("in_window %0b, expected %0b", got.in_window, want.in_window));
    endtask
  endclass

  logic clk;
  logic rst_n;

  mwrs_in_if  in_bus();
  mwrs_out_if out_bus();
  mwrs_cfg_if cfg_bus();

  mass_window_range_search #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  window_scoreboard sb = new();

  int cycle_count;
  int items_sent;
  int filled;
  int hold_asks;
  int hold_seen;
  int stall_left;
  int rx_roll;
  bit rx_steady;
  bit tx_quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("mass_window_range_search_test: errors");
    $finish;
  end

  // Inputs are noted before results so a result and a new query on one edge stay in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready)
        sb.note_item(in_bus.op, in_bus.entry_index, in_bus.entry_mass, in_bus.query_mass);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(window_t'{out_bus.low_index, out_bus.high_index, out_bus.in_window});
    end
  end

  // Result receiver: random stalls, steady stretches, and a long hold on request.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen  = hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (rx_steady) begin
        out_bus.ready <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 70) begin
          out_bus.ready <= 1'b1;
        end else if (rx_roll < 95) begin
          out_bus.ready <= 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_bus.ready <= 1'b0;
          stall_left = $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [MASS_W-1:0] emass,
                           logic [MASS_W-1:0] qmass);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.op          <= op;
    in_bus.entry_index <= idx;
    in_bus.entry_mass  <= emass;
    in_bus.query_mass  <= qmass;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // Loads keep the written region as one past the highest index loaded.
  task automatic send_load(int idx, logic [MASS_W-1:0] m);
    send_item(OP_LOAD, idx[IDX_W-1:0], m, $urandom);
    if (idx >= filled) filled = idx + 1;
  endtask

  task automatic send_query(logic [MASS_W-1:0] q);
    send_item(OP_QUERY, IDX_W'($urandom), $urandom, q);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Stop offering, wait for every awaited range, then let a trailing load finish.
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_masses(int n, shape_t shape, int step_max);
    longint            acc, headroom;
    logic [MASS_W-1:0] flat;
    flat     = $urandom;
    headroom = longint'(MASS_MAX) - longint'(n) * step_max / 2;
    if (headroom < 0) headroom = 0;
    if (shape == SHAPE_TOP) begin
      acc = longint'(MASS_MAX) - longint'(n) * step_max / 4;
      if (acc < 0) acc = 0;
    end else begin
      acc = longint'($urandom_range(0, headroom[31:0]));
    end
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_UNSORTED: send_load(i, $urandom);
        SHAPE_FLAT:     send_load(i, flat);
        default: begin
          send_load(i, (acc > longint'(MASS_MAX)) ? MASS_MAX : acc[MASS_W-1:0]);
          // A quarter of the steps repeat the previous mass to build equal runs.
          if ($urandom_range(0, 3) != 0) acc += longint'($urandom_range(1, step_max));
        end
      endcase
    end
  endtask

  function automatic logic [MASS_W-1:0] pick_query(int n, longint spread);
    longint v;
    int     r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return ($urandom_range(0, 1) == 0) ? '0 : MASS_MAX;
    v = sb.mass_of($urandom_range(0, n - 1)) + longint'($urandom_range(0, 2 * spread))
        - spread;
    if (v < 0) v = 0;
    if (v > longint'(MASS_MAX)) v = longint'(MASS_MAX);
    return v[MASS_W-1:0];
  endfunction

  function automatic logic [MASS_W-1:0] pick_tolerance(int step_max);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r == 2) return 32'h8000_0000;
    if (r == 3) return '1;
    if (r < 6) return $urandom;
    if (r < 8) return {1'b1, 31'($urandom)};
    return $urandom_range(0, 2 * step_max);
  endfunction

  // A phase that would read past the written region reloads the table first.
  task automatic run_phase(logic [CFG_W-1:0] count_word, logic [CFG_W-1:0] tol_word,
                           shape_t shape, int step_max, int queries, bit reload,
                           bit hold_off);
    int     n;
    longint spread;
    settle();
    write_register(REG_ENTRY_COUNT, count_word);
    write_register(REG_TOLERANCE, tol_word);
    n = sb.entries_for(count_word[COUNT_W-1:0]);
    if (reload || n > filled) load_masses(n, shape, step_max);
    if (tol_word[MASS_W-1] || tol_word > 32'h2000_0000)
      spread = $urandom_range(16, 32'h0010_0000);
    else
      spread = longint'(tol_word) + longint'(tol_word >> 1) + 16;
    if (hold_off) hold_asks++;
    repeat (queries) begin
      if ($urandom_range(0, 11) == 0) send_load($urandom_range(0, n - 1), $urandom);
      else send_query(pick_query(n, spread));
    end
  endtask

  initial begin
    logic [MASS_W-1:0] ladder [8];
    logic [MASS_W-1:0] edge_tol [4];
    logic [MASS_W-1:0] edge_query [4];
    logic [CFG_W-1:0]  count_word;
    int                step_max, r;
    bit                first_pass;
    shape_t            shape;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.op          = OP_LOAD;
    in_bus.entry_index = '0;
    in_bus.entry_mass  = '0;
    in_bus.query_mass  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_TOLERANCE;
    cfg_bus.data       = '0;
    rx_steady          = 1'b1;
    tx_quiet           = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One entry under the reset settings: inside, below and above the table.
    send_load(0, 32'h0064_0000);
    send_query(32'h0064_0000);
    send_query(32'h005F_0000);
    send_query('0);
    send_query(MASS_MAX);

    // Eight entries with an equal run and both mass extremes.
    ladder = '{32'h0000_0000, 32'h0014_0000, 32'h0014_0000, 32'h0014_0000,
               32'h001E_0000, 32'h0028_0000, 32'h0028_0000, MASS_MAX};
    settle();
    write_register(REG_ENTRY_COUNT, 32'd8);
    write_register(REG_TOLERANCE, 32'h0001_0000);
    for (int i = 0; i < 8; i++) send_load(i, ladder[i]);
    send_query(32'h0014_0000);
    send_query(32'h0019_0000);
    send_query(32'h0028_8000);
    send_query(MASS_MAX);
    send_query('0);

    // Zero tolerance, negative tolerances and the largest positive one.
    edge_tol   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    edge_query = '{32'h001E_0000, 32'h001E_0000, 32'h0000_0000, 32'h8000_0000};
    for (int i = 0; i < 4; i++) begin
      settle();
      write_register(REG_TOLERANCE, edge_tol[i]);
      send_query(edge_query[i]);
    end

    // A wider sorted prefix for longer searches; high count bits must be dropped.
    settle();
    write_register(REG_ENTRY_COUNT, 32'(PREFIX_FILL));
    tx_quiet = 1'b1;
    load_masses(PREFIX_FILL, SHAPE_SORTED, 32'hFFFF);
    tx_quiet = 1'b0;
    rx_steady = 1'b0;
    run_phase(32'h0000_0200, 32'h0000_8000, SHAPE_SORTED, 0, 12, 1'b0, 1'b0);
    run_phase(32'h0000_0200, 32'h0004_0000, SHAPE_SORTED, 0, 12, 1'b0, 1'b0);
    run_phase(32'h0000_0200, 32'h0000_0000, SHAPE_SORTED, 0, 8, 1'b0, 1'b0);
    run_phase(32'hFFFE_0200, 32'h7FFF_FFFF, SHAPE_SORTED, 0, 6, 1'b0, 1'b0);
    run_phase(32'hFFFE_0200, 32'h0001_0000, SHAPE_SORTED, 0, 10, 1'b0, 1'b0);
    run_phase(32'h0000_0000, 32'h0002_0000, SHAPE_SORTED, 0, 6, 1'b0, 1'b0);

    first_pass = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 3);
      step_max = (r == 0) ? 1 : (r == 1) ? 32'h100 : (r == 2) ? 32'h1_0000 : 32'h10_0000;
      r = $urandom_range(0, 19);
      if (r < 3) count_word = r;
      else if (r < 6) count_word = $urandom_range(33, 300);
      else count_word = $urandom_range(3, 32);
      // Bits above the register width must be dropped by the block.
      if ($urandom_range(0, 3) == 0) count_word = count_word | ($urandom << COUNT_W);
      r = $urandom_range(0, 19);
      shape = (r < 13) ? SHAPE_SORTED : (r < 15) ? SHAPE_TOP :
              (r < 18) ? SHAPE_UNSORTED : SHAPE_FLAT;
      rx_steady = ($urandom_range(0, 3) == 0);
      tx_quiet  = first_pass || ($urandom_range(0, 3) == 0);
      run_phase(count_word, pick_tolerance(step_max), shape, step_max,
                $urandom_range(5, 30), $urandom_range(0, 4) != 0, first_pass);
      first_pass = 1'b0;
    end

    settle();
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d ranges never returned", sb.awaited.size()));
    if (sb.errors == 0) begin
      $display("mass_window_range_search_test: clean");
    end else begin
      $display("mass_window_range_search_test: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mwrs_pkg.sv
rtl/mwrs_in_if.sv
rtl/mwrs_out_if.sv
rtl/mwrs_cfg_if.sv
rtl/mwrs_ram.sv
rtl/mass_window_range_search.sv
rtl/mwrs_checker.sv
bench/mass_window_range_search_test.sv
